### rtl/crb_pkg.sv
`timescale 1ns / 1ps

package crb_pkg;

  // Width of positions and run lengths within one level.
  localparam int POS_W = 16;
  // Width of a level index.
  localparam int LEVEL_W = 4;
  // Entries in one level before the position counter wraps.
  localparam int MAX_LEVEL_ENTRIES = 65536;
  // Last position before the counter returns to zero.
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(MAX_LEVEL_ENTRIES - 1);
  // A run shorter than this is never emitted, whatever the configuration.
  localparam logic [POS_W-1:0] MIN_FLOOR = POS_W'(2);

  // Configuration bus widths.
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // Register index taken from the word address bit of paddr.
  typedef enum logic {
    REG_MIN_RUN_WIDTH = 1'b0,
    REG_MAX_RUN_WIDTH = 1'b1
  } reg_idx_t;

  // Result of one entry's step through the run tracker.
  typedef struct packed {
    logic               emit;
    logic [POS_W-1:0]   start;
    logic [POS_W-1:0]   length;
    logic [LEVEL_W-1:0] level;
  } run_result_t;

endpackage

### rtl/crb_cfg_regs.sv
`timescale 1ns / 1ps

module crb_cfg_regs
  import crb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [POS_W-1:0]      min_run_width,
  output logic [POS_W-1:0]      max_run_width
);

  reg_idx_t reg_idx;
  logic     wr_en;

  // Word address selects the register; byte offset bits are ignored.
  assign reg_idx = reg_idx_t'(paddr[2]);
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  // Register writes complete in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_run_width <= POS_W'(2);
      max_run_width <= POS_W'(65535);
    end else if (wr_en) begin
      case (reg_idx)
        REG_MIN_RUN_WIDTH: min_run_width <= pwdata[POS_W-1:0];
        REG_MAX_RUN_WIDTH: max_run_width <= pwdata[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // Read data is driven straight from the selected register.
  always_comb begin
    case (reg_idx)
      REG_MIN_RUN_WIDTH: prdata = APB_DATA_W'(min_run_width);
      REG_MAX_RUN_WIDTH: prdata = APB_DATA_W'(max_run_width);
      default:           prdata = '0;
    endcase
  end

endmodule

### rtl/crb_run_tracker.sv
`timescale 1ns / 1ps

module crb_run_tracker
  import crb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic               pickable,
  input  logic               last_in_level,
  input  logic [LEVEL_W-1:0] level_number,
  input  logic [POS_W-1:0]   min_run_width,
  input  logic [POS_W-1:0]   max_run_width,
  output run_result_t        result
);

  logic [POS_W-1:0] entry_position;
  logic [POS_W-1:0] open_start;
  logic [POS_W-1:0] open_length;
  logic [POS_W-1:0] entry_position_next;
  logic [POS_W-1:0] open_start_next;
  logic [POS_W-1:0] open_length_next;
  logic [POS_W-1:0] grow_start;
  logic [POS_W-1:0] grow_length;
  logic [POS_W-1:0] need;
  logic             close_old;
  logic             emit_old;
  logic             emit_tail;

  // Effective minimum never drops below two entries.
  assign need = (min_run_width < MIN_FLOOR) ? MIN_FLOOR : min_run_width;

  // Extend, start or restart the open run for this entry.
  always_comb begin
    grow_start  = open_start;
    grow_length = open_length;
    close_old   = 1'b0;
    if (pickable) begin
      if (open_length == '0) begin
        grow_start  = entry_position;
        grow_length = POS_W'(1);
      end else if (open_length < max_run_width) begin
        grow_length = open_length + POS_W'(1);
      end else begin
        close_old   = 1'b1;
        grow_start  = entry_position;
        grow_length = POS_W'(1);
      end
    end else if (open_length != '0) begin
      close_old   = 1'b1;
      grow_start  = '0;
      grow_length = '0;
    end
  end

  // The old run is emitted when it closes long enough; otherwise the end of
  // the level may emit the run that is open after this entry.
  assign emit_old  = close_old && (open_length >= need);
  assign emit_tail = last_in_level && !emit_old && (grow_length >= need);

  always_comb begin
    result.emit   = emit_old || emit_tail;
    result.start  = emit_old ? open_start  : grow_start;
    result.length = emit_old ? open_length : grow_length;
    result.level  = level_number;
  end

  // End of level restarts the position and drops any open run.
  always_comb begin
    if (last_in_level) begin
      entry_position_next = '0;
      open_start_next     = '0;
      open_length_next    = '0;
    end else begin
      entry_position_next = (entry_position == LAST_POS) ? '0
                                                         : entry_position + POS_W'(1);
      open_start_next     = grow_start;
      open_length_next    = grow_length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_position <= '0;
      open_start     <= '0;
      open_length    <= '0;
    end else if (step) begin
      entry_position <= entry_position_next;
      open_start     <= open_start_next;
      open_length    <= open_length_next;
    end
  end

endmodule

### rtl/compaction_run_bucketer.sv
// Groups the entries of a storage level, presented one per transaction in
// level order, into compaction runs of consecutive pickable entries and
// emits each run that reaches min_run_width, and at least two entries, as
// (run_start, run_length, run_level). The block takes one entry per cycle
// while the downstream side is not stalling. An entry is captured in the
// input register at its input transaction and is processed once the output
// register is free or being emptied; its run, if any, is then loaded into
// the output register, which raises out_valid. The open-run registers are
// updated as each entry moves on. in_stall rises only while the output
// register holds a result that the downstream side is stalling.
`timescale 1ns / 1ps

module compaction_run_bucketer
  import crb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  pickable,
  input  logic                  last_in_level,
  input  logic [LEVEL_W-1:0]    level_number,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [POS_W-1:0]      run_start,
  output logic [POS_W-1:0]      run_length,
  output logic [LEVEL_W-1:0]    run_level
);

  logic [POS_W-1:0]   min_run_width;
  logic [POS_W-1:0]   max_run_width;
  logic               in_full;
  logic               pick_r;
  logic               last_r;
  logic [LEVEL_W-1:0] level_r;
  logic               in_accept;
  logic               advance;
  run_result_t        result;

  crb_cfg_regs u_cfg_regs (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .min_run_width (min_run_width),
    .max_run_width (max_run_width)
  );

  // An entry moves on when the output register is free or being emptied.
  assign advance   = in_full && (!out_valid || !out_stall);
  assign in_stall  = in_full && !advance;
  assign in_accept = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_accept) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      pick_r  <= pickable;
      last_r  <= last_in_level;
      level_r <= level_number;
    end
  end

  crb_run_tracker u_run_tracker (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .pickable      (pick_r),
    .last_in_level (last_r),
    .level_number  (level_r),
    .min_run_width (min_run_width),
    .max_run_width (max_run_width),
    .result        (result)
  );

  // Output register: holds a result until the downstream transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && result.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.emit) begin
      run_start  <= result.start;
      run_length <= result.length;
      run_level  <= result.level;
    end
  end

endmodule

### tb/sv/compaction_run_checker.sv
`timescale 1ns / 1ps

// Watches the configuration port and both channels of the run bucketer,
// predicts the runs that every accepted entry closes, and compares each
// output transaction against the oldest predicted run.
module compaction_run_checker
  import crb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic                  pickable,
  input  logic                  last_in_level,
  input  logic [LEVEL_W-1:0]    level_number,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [POS_W-1:0]      run_start,
  input  logic [POS_W-1:0]      run_length,
  input  logic [LEVEL_W-1:0]    run_level,
  output int                    mismatch_count,
  output int                    runs_pending
);

  // A run is never emitted below two entries, whatever the register says.
  localparam logic [POS_W-1:0] SHORTEST_RUN = POS_W'(2);

  typedef struct packed {
    logic [POS_W-1:0]   start;
    logic [POS_W-1:0]   length;
    logic [LEVEL_W-1:0] level;
  } run_t;

  run_t expected_runs[$];

  // Shadow copy of the registers and of the run tracker.
  logic [POS_W-1:0] min_width;
  logic [POS_W-1:0] max_width;
  logic [POS_W-1:0] next_pos;
  logic [POS_W-1:0] open_start;
  logic [POS_W-1:0] open_len;
  int               errs;

  // Closes the open run and queues it if it is long enough.
  task automatic close_open_run(input logic [LEVEL_W-1:0] lvl, output logic emitted);
    logic [POS_W-1:0] need;
    run_t             run;
    need = (min_width < SHORTEST_RUN) ? SHORTEST_RUN : min_width;
    emitted = 1'b0;
    if (open_len != '0 && open_len >= need) begin
      run.start = open_start;
      run.length = open_len;
      run.level = lvl;
      expected_runs = {expected_runs, run};
      emitted = 1'b1;
    end
    open_len = '0;
    open_start = '0;
  endtask

  // Advances the tracker by one entry of the level.
  task automatic bucket_entry(input logic pick, input logic last,
                              input logic [LEVEL_W-1:0] lvl);
    logic emitted;
    emitted = 1'b0;
    if (pick) begin
      if (open_len == '0) begin
        open_start = next_pos;
        open_len = POS_W'(1);
      end else if (open_len < max_width) begin
        open_len = open_len + POS_W'(1);
      end else begin
        close_open_run(lvl, emitted);
        open_start = next_pos;
        open_len = POS_W'(1);
      end
    end else if (open_len != '0) begin
      close_open_run(lvl, emitted);
    end
    if (last) begin
      if (!emitted) begin
        close_open_run(lvl, emitted);
      end
      open_len = '0;
      open_start = '0;
      next_pos = '0;
    end else begin
      next_pos = next_pos + POS_W'(1);
    end
  endtask

  // Compares one output transaction with the oldest predicted run.
  task automatic check_run();
    run_t want;
    if (expected_runs.size() == 0) begin
      $error("unexpected run: start %0d, length %0d, level %0d",
             run_start, run_length, run_level);
      errs++;
    end else begin
      want = expected_runs.pop_front();
      if (run_start !== want.start) begin
        $error("run_start: expected %0d, got %0d", want.start, run_start);
        errs++;
      end
      if (run_length !== want.length) begin
        $error("run_length: expected %0d, got %0d", want.length, run_length);
        errs++;
      end
      if (run_level !== want.level) begin
        $error("run_level: expected %0d, got %0d", want.level, run_level);
        errs++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      min_width = POS_W'(2);
      max_width = POS_W'(65535);
      next_pos = '0;
      open_start = '0;
      open_len = '0;
      errs = 0;
      expected_runs.delete();
    end else begin
      // Register writes complete in the access phase.
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[2]))
          REG_MIN_RUN_WIDTH: min_width = pwdata[POS_W-1:0];
          REG_MAX_RUN_WIDTH: max_width = pwdata[POS_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        check_run();
      end
      if (in_valid && !in_stall) begin
        bucket_entry(pickable, last_in_level, level_number);
      end
    end
    mismatch_count <= errs;
    runs_pending <= expected_runs.size();
  end

endmodule

### tb/sv/tb_compaction_run_bucketer.sv
`timescale 1ns / 1ps

module tb_compaction_run_bucketer;
  import crb_pkg::*;

  localparam int LONG_HOLD = 300;
  localparam int SETTLE_CYCLES = 6;
  localparam int PHASE_ENTRIES = 195;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  pickable = 1'b0;
  logic                  last_in_level = 1'b0;
  logic [LEVEL_W-1:0]    level_number = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [POS_W-1:0]      run_start;
  logic [POS_W-1:0]      run_length;
  logic [LEVEL_W-1:0]    run_level;

  int mismatch_count;
  int runs_pending;
  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;
  int hold_requests = 0;
  int entries_sent = 0;

  compaction_run_bucketer dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .pickable(pickable), .last_in_level(last_in_level), .level_number(level_number),
    .out_valid(out_valid), .out_stall(out_stall),
    .run_start(run_start), .run_length(run_length), .run_level(run_level)
  );

  compaction_run_checker u_checker (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .pickable(pickable), .last_in_level(last_in_level), .level_number(level_number),
    .out_valid(out_valid), .out_stall(out_stall),
    .run_start(run_start), .run_length(run_length), .run_level(run_level),
    .mismatch_count(mismatch_count), .runs_pending(runs_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
    end
  end

  // Offers one entry, with random idle cycles ahead of it, until it is taken.
  task automatic send_entry(input logic pick, input logic last,
                            input logic [LEVEL_W-1:0] lvl);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pickable <= pick;
    last_in_level <= last;
    level_number <= lvl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    entries_sent++;
  endtask

  // One register write: setup cycle, access cycle, then psel is dropped to idle.
  task automatic write_reg(input reg_idx_t idx, input logic [POS_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_ADDR_W'(idx) << 2;
    pwdata <= {16'($urandom()), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Stops offering entries and lets every outstanding run drain.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (runs_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // A well-formed level of random length and pickability, with some noise.
  task automatic send_random_level(input int longest);
    int                 len;
    int                 pick_pct;
    logic [LEVEL_W-1:0] lvl;
    len = $urandom_range(longest, 1);
    pick_pct = $urandom_range(95, 40);
    lvl = LEVEL_W'($urandom());
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(19) == 0) begin
        send_entry(1'($urandom()), 1'($urandom()), LEVEL_W'($urandom()));
      end else begin
        send_entry($urandom_range(99) < pick_pct, i == len - 1,
                   ($urandom_range(15) == 0) ? LEVEL_W'($urandom()) : lvl);
      end
    end
  endtask

  // One random phase under a fresh configuration and idling mix.
  task automatic run_phase(input logic [POS_W-1:0] min_w, input logic [POS_W-1:0] max_w,
                           input int send_pct, input int recv_pct,
                           input int longest, input bit hold);
    int goal;
    wait_quiet();
    write_reg(REG_MIN_RUN_WIDTH, min_w);
    write_reg(REG_MAX_RUN_WIDTH, max_w);
    sender_idle_pct = send_pct;
    receiver_idle_pct = recv_pct;
    if (hold) hold_requests++;
    goal = entries_sent + PHASE_ENTRIES;
    while (entries_sent < goal) send_random_level(longest);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    sender_idle_pct = 18;
    receiver_idle_pct = 82;

    // Directed entries under the reset configuration.
    send_entry(1'b1, 1'b1, 4'd0);   // lone pickable entry at end of level
    send_entry(1'b1, 1'b0, 4'd15);
    send_entry(1'b1, 1'b1, 4'd15);  // run of two closed by end of level
    send_entry(1'b0, 1'b0, 4'd0);
    send_entry(1'b1, 1'b0, 4'd3);
    send_entry(1'b1, 1'b0, 4'd3);
    send_entry(1'b1, 1'b0, 4'd3);
    send_entry(1'b0, 1'b0, 4'd5);   // level taken from the closing entry
    send_entry(1'b1, 1'b0, 4'd7);
    send_entry(1'b1, 1'b0, 4'd7);
    send_entry(1'b0, 1'b1, 4'd12);  // non-pickable last entry closes the run
    send_entry(1'b0, 1'b1, 4'd0);   // level with no pickable entry
    send_entry(1'b1, 1'b0, 4'd1);
    send_entry(1'b1, 1'b0, 4'd2);
    send_entry(1'b1, 1'b1, 4'd4);

    // Full runs with a tiny maximum and a minimum below the floor.
    wait_quiet();
    write_reg(REG_MIN_RUN_WIDTH, 16'd0);
    write_reg(REG_MAX_RUN_WIDTH, 16'd3);
    repeat (5) send_entry(1'b1, 1'b0, 4'd6);
    send_entry(1'b1, 1'b1, 4'd6);
    repeat (3) send_entry(1'b1, 1'b0, 4'd8);
    send_entry(1'b1, 1'b1, 4'd8);   // full run closed, new run dropped at end

    // Random phases, cycling through the idling mixes.
    run_phase(16'd2, 16'd65535, 18, 82, 20, 1'b0);
    run_phase(16'd0, 16'd3, 82, 18, 12, 1'b0);
    run_phase(16'd3, 16'd4, 0, 0, 14, 1'b1);
    run_phase(16'd6, 16'd4, 18, 82, 16, 1'b0);
    run_phase(16'd1, 16'd1, 82, 18, 10, 1'b0);
    run_phase(16'd0, 16'd0, 0, 0, 10, 1'b0);
    run_phase(16'd2, 16'd8, 18, 82, 24, 1'b0);
    run_phase(16'd5, 16'd65535, 82, 18, 30, 1'b0);
    run_phase(16'd2, 16'd2, 0, 0, 12, 1'b1);

    wait_quiet();
    if (mismatch_count == 0 && runs_pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #20000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
